>>> rtl/brfs_pkg.sv
// ----------------------------------------------------------------------------
// brfs_pkg
// Shared types and constants for the byte ring FIFO with search.
// ----------------------------------------------------------------------------
package brfs_pkg;

    localparam int BYTE_W  = 8;
    localparam int REQ_W   = 2;

    // Request kinds carried on the slave tuser
    localparam logic [REQ_W-1:0] REQ_PUSH   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_POP    = 2'd1;
    localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd2;

    localparam logic [BYTE_W-1:0] NO_BYTE = 8'h00;

    // Result beat: 13 payload bits padded to two bytes
    localparam int OUT_BITS = 13;
    localparam int OUT_W    = 16;

    // Broadcast from the controller to every cell
    typedef struct packed {
        logic              push;     // store the byte into the first free cell
        logic              pop;      // shift the chain toward the head
        logic [BYTE_W-1:0] wr_byte;  // byte being pushed
        logic [BYTE_W-1:0] key;      // search key, held for the whole scan
    } t_cell_ctrl;

endpackage

>>> rtl/byte_ring_fifo_with_search.sv
// Byte FIFO with search, holding up to DEPTH-1 bytes in a chain of cells with
// the oldest byte at the head. A new beat is accepted every cycle as long as
// the result beat is taken and no search is in progress. During a search the
// match flag of each cell ripples one cell per cycle toward the head, so the
// length of the chain sets the scan time, and no beat is accepted meanwhile.
// Every result beat carries the empty and full flags as they stood before its
// request.
// ----------------------------------------------------------------------------
// byte_ring_fifo_with_search
// Top level: stream handshake, request decode, result register and the cell
// chain.
// ----------------------------------------------------------------------------
module byte_ring_fifo_with_search #(
    parameter int DEPTH = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // slave side
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [brfs_pkg::BYTE_W-1:0]    s_axis_tdata,   // [7:0] data_byte
    input  logic [brfs_pkg::REQ_W-1:0]     s_axis_tuser,   // [1:0] req_type
    // master side
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [brfs_pkg::OUT_W-1:0]     m_axis_tdata    // [0] push_ok, [8:1] pop_byte,
                                                           // [9] pop_valid, [10] found,
                                                           // [11] was_empty, [12] was_full
);
    import brfs_pkg::*;

    localparam int NCELL = DEPTH - 1;
    localparam int CNT_W = $clog2(DEPTH);
    localparam logic [CNT_W-1:0] SCAN_LAST = CNT_W'(NCELL);

    // Cell chain wiring, one extra entry at the tail end for the boundary
    logic [BYTE_W-1:0] w_data [0:NCELL];
    logic              w_full [0:NCELL];
    logic              w_hit  [0:NCELL];
    logic              w_head_full;
    t_cell_ctrl        w_ctrl;

    logic              w_empty, w_full_flag;
    logic              w_accept, w_out_free, w_scan_done;

    logic              r_busy,  n_busy;
    logic [CNT_W-1:0]  r_cnt,   n_cnt;
    logic [BYTE_W-1:0] r_key,   n_key;
    logic              r_s_empty, n_s_empty;
    logic              r_s_full,  n_s_full;

    logic              r_out_valid, n_out_valid;
    logic              r_push_ok,   n_push_ok;
    logic [BYTE_W-1:0] r_pop_byte,  n_pop_byte;
    logic              r_pop_valid, n_pop_valid;
    logic              r_found,     n_found;
    logic              r_was_empty, n_was_empty;
    logic              r_was_full,  n_was_full;

    // Flags straight from the ends of the chain
    assign w_head_full = 1'b1;
    assign w_empty     = !w_full[0];
    assign w_full_flag = w_full[NCELL-1];

    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_busy && w_out_free;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_scan_done   = r_busy && (r_cnt == SCAN_LAST);

    // Broadcast to the cells
    always_comb begin
        w_ctrl.push    = w_accept && (s_axis_tuser == REQ_PUSH) && !w_full_flag;
        w_ctrl.pop     = w_accept && (s_axis_tuser == REQ_POP) && !w_empty;
        w_ctrl.wr_byte = s_axis_tdata;
        w_ctrl.key     = r_key;
    end

    // Tail boundary: nothing shifts in, no match beyond the last cell
    assign w_data[NCELL] = NO_BYTE;
    assign w_full[NCELL] = 1'b0;
    assign w_hit[NCELL]  = 1'b0;

    genvar gi;
    generate
        for (gi = 0; gi < NCELL; gi++) begin : g_chain
            brfs_cell u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_ctrl      (w_ctrl),
                .i_prev_full ((gi == 0) ? w_head_full : w_full[(gi == 0) ? 0 : gi-1]),
                .i_next_data (w_data[gi+1]),
                .i_next_full (w_full[gi+1]),
                .i_next_hit  (w_hit[gi+1]),
                .o_data      (w_data[gi]),
                .o_full      (w_full[gi]),
                .o_hit       (w_hit[gi])
            );
        end
    endgenerate

    // Request decode, scan sequencing and result register
    always_comb begin
        n_busy      = r_busy;
        n_cnt       = r_cnt;
        n_key       = r_key;
        n_s_empty   = r_s_empty;
        n_s_full    = r_s_full;
        n_out_valid = r_out_valid;
        n_push_ok   = r_push_ok;
        n_pop_byte  = r_pop_byte;
        n_pop_valid = r_pop_valid;
        n_found     = r_found;
        n_was_empty = r_was_empty;
        n_was_full  = r_was_full;

        if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        if (w_accept) begin
            n_push_ok   = 1'b0;
            n_pop_byte  = NO_BYTE;
            n_pop_valid = 1'b0;
            n_found     = 1'b0;
            n_was_empty = w_empty;
            n_was_full  = w_full_flag;
            case (s_axis_tuser)
                REQ_PUSH: begin
                    n_push_ok   = !w_full_flag;
                    n_out_valid = 1'b1;
                end
                REQ_POP: begin
                    n_pop_valid = !w_empty;
                    n_pop_byte  = w_empty ? NO_BYTE : w_data[0];
                    n_out_valid = 1'b1;
                end
                REQ_SEARCH: begin
                    n_busy    = 1'b1;
                    n_cnt     = '0;
                    n_key     = s_axis_tdata;
                    n_s_empty = w_empty;
                    n_s_full  = w_full_flag;
                end
                default: begin
                    n_out_valid = 1'b1;
                end
            endcase
        end else if (w_scan_done) begin
            // Hit chain has settled; wait for the result slot
            if (w_out_free) begin
                n_busy      = 1'b0;
                n_out_valid = 1'b1;
                n_push_ok   = 1'b0;
                n_pop_byte  = NO_BYTE;
                n_pop_valid = 1'b0;
                n_found     = w_hit[0];
                n_was_empty = r_s_empty;
                n_was_full  = r_s_full;
            end
        end else if (r_busy) begin
            n_cnt = r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key       <= n_key;
        r_s_empty   <= n_s_empty;
        r_s_full    <= n_s_full;
        r_push_ok   <= n_push_ok;
        r_pop_byte  <= n_pop_byte;
        r_pop_valid <= n_pop_valid;
        r_found     <= n_found;
        r_was_empty <= n_was_empty;
        r_was_full  <= n_was_full;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_W-OUT_BITS){1'b0}}, r_was_full, r_was_empty, r_found,
                            r_pop_valid, r_pop_byte, r_push_ok};

endmodule

>>> rtl/brfs_cell.sv
// ----------------------------------------------------------------------------
// brfs_cell
// One storage cell of the FIFO chain: a byte, an occupied flag and a match
// flag that ripples toward the head one cell per cycle.
// ----------------------------------------------------------------------------
module brfs_cell (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  brfs_pkg::t_cell_ctrl             i_ctrl,
    input  logic                             i_prev_full,  // cell nearer the head
    input  logic [brfs_pkg::BYTE_W-1:0]      i_next_data,  // cell nearer the tail
    input  logic                             i_next_full,
    input  logic                             i_next_hit,
    output logic [brfs_pkg::BYTE_W-1:0]      o_data,
    output logic                             o_full,
    output logic                             o_hit
);
    import brfs_pkg::*;

    logic [BYTE_W-1:0] r_data, n_data;
    logic              r_full, n_full;
    logic              r_hit,  n_hit;

    // Pop shifts toward the head; push fills the first empty cell
    always_comb begin
        n_data = r_data;
        n_full = r_full;
        if (i_ctrl.pop) begin
            n_data = i_next_data;
            n_full = i_next_full;
        end else if (i_ctrl.push && !r_full && i_prev_full) begin
            n_data = i_ctrl.wr_byte;
            n_full = 1'b1;
        end
        // Match chain: local compare OR'd with the tail side
        n_hit = (r_full && (r_data == i_ctrl.key)) || i_next_hit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
        end else begin
            r_full <= n_full;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_hit  <= n_hit;
    end

    assign o_data = r_data;
    assign o_full = r_full;
    assign o_hit  = r_hit;

endmodule
